FILE: rtl/core/deq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

  localparam int OP_W  = 3;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;
  localparam int CNT_W = 11;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_CMP_FRONT  = 3'd4;
  localparam logic [OP_W-1:0] OP_CMP_BACK   = 3'd5;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd6;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_MISS = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic cmp_front;
    logic cmp_back;
  } cell_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/deq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module deq_cell
  import deq_pkg::*;
#(
  parameter int CW  = 11,
  parameter int IDX = 0
) (
  input  wire logic                    clk_i,
  input  wire logic signed [VAL_W-1:0] value_i,
  input  wire logic signed [VAL_W-1:0] prev_i,
  input  wire logic signed [VAL_W-1:0] next_i,
  input  wire logic        [CW-1:0]    count_i,
  input  wire cell_cmd_t               cmd_i,
  output logic signed      [VAL_W-1:0] data_o,
  output logic                         hit_o
);

  localparam logic [CW-1:0] IDX_C = CW'(IDX);
  localparam logic [CW-1:0] IDX_N = CW'(IDX + 1);

  logic signed [VAL_W-1:0] data_q;
  logic signed [VAL_W-1:0] data_d;
  logic                    occ;
  logic                    last;

  assign occ  = count_i > IDX_C;
  assign last = count_i == IDX_N;

  always_comb begin
    data_d = data_q;
    if (cmd_i.push_front) begin
      data_d = prev_i;
    end else if (cmd_i.pop_front) begin
      data_d = next_i;
    end else if (cmd_i.push_back && (count_i == IDX_C)) begin
      data_d = value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign hit_o  = (data_q == value_i) &&
                  ((cmd_i.cmp_front && occ && (IDX == 0)) || (cmd_i.cmp_back && last));

endmodule

`default_nettype wire

FILE: rtl/core/deq_or_tree.sv
`timescale 1ns / 1ps
`default_nettype none

module deq_or_tree #(
  parameter int N = 1024
) (
  input  wire logic         clk_i,
  input  wire logic [N-1:0] hit_i,
  output logic              any_o
);

  localparam int GRP = 32;
  localparam int NG  = (N + GRP - 1) / GRP;

  logic [NG-1:0] grp_d;
  logic [NG-1:0] grp_q;

  for (genvar g = 0; g < NG; g++) begin : g_grp
    localparam int LO = g * GRP;
    localparam int HI = (LO + GRP > N) ? N - 1 : LO + GRP - 1;
    assign grp_d[g] = |hit_i[HI:LO];
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

  assign any_o = |grp_q;

endmodule

`default_nettype wire

FILE: rtl/core/double_ended_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Bounded double-ended queue of signed 32-bit values, held in a row of DEPTH
// cells with the front element always in cell 0 and the back in cell count-1.
// Command channel: an item (op_i, value_i) is taken at a rising edge where
// start is high and busy is low; busy stays high in the match and apply cycles.
// Result channel: status_o, count_o and is_empty_o are shown for exactly one
// cycle, marked by valid_o, registered at the end of the apply cycle; the
// receiver cannot hold them off and need not, as each item gives one result.
// A new item is taken only once busy is low again, which is in the same
// cycle as the previous result is shown. The match cycle compares the front
// or back cell with the value and registers 32-way ORs of the hits; the apply
// cycle finishes the OR, shifts the cell row and updates the count.
// Pushes shift the row or fill the slot at the count; pops shift the row or
// lower the count. A push onto a full queue is refused with status full.
// Reset empties the queue (count zero) and clears busy and valid_o at once;
// cell contents are not cleared and are never read unless written.

module double_ended_queue
  import deq_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic        [OP_W-1:0]  op_i,
  input  wire logic signed [VAL_W-1:0] value_i,
  output logic                         valid_o,
  output logic             [ST_W-1:0]  status_o,
  output logic             [CNT_W-1:0] count_o,
  output logic                         is_empty_o
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_C = CW'(DEPTH);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_MATCH = 2'd1;
  localparam logic [1:0] PH_APPLY = 2'd2;

  logic [1:0]              phase_q;
  logic [1:0]              phase_d;
  logic [OP_W-1:0]         op_q;
  logic signed [VAL_W-1:0] val_q;
  logic [CW-1:0]           count_q;
  logic [CW-1:0]           count_d;
  logic [ST_W-1:0]         st_d;
  logic                    accept;
  logic                    any_hit;
  logic                    full;
  logic                    empty;
  cell_cmd_t               cmd;
  cell_cmd_t               wr;

  logic signed [VAL_W-1:0] data_w [DEPTH];
  logic [DEPTH-1:0]        hit_w;

  assign busy   = phase_q != PH_IDLE;
  assign accept = start && !busy;
  assign full   = count_q == FULL_C;
  assign empty  = count_q == '0;

  always_comb begin
    wr      = '0;
    st_d    = ST_OK;
    count_d = count_q;
    case (op_q)
      OP_PUSH_FRONT: begin
        if (full) begin
          st_d = ST_FULL;
        end else begin
          wr.push_front = 1'b1;
          count_d       = count_q + CW'(1);
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          st_d = ST_FULL;
        end else begin
          wr.push_back = 1'b1;
          count_d      = count_q + CW'(1);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          st_d = ST_MISS;
        end else begin
          wr.pop_front = 1'b1;
          count_d      = count_q - CW'(1);
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          st_d = ST_MISS;
        end else begin
          count_d = count_q - CW'(1);
        end
      end
      OP_CMP_FRONT, OP_CMP_BACK: begin
        if (!any_hit) begin
          st_d = ST_MISS;
        end
      end
      OP_CLEAR: begin
        count_d = '0;
      end
      default: begin
        st_d = ST_OK;
      end
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.cmp_front  = op_q == OP_CMP_FRONT;
    cmd.cmp_back   = op_q == OP_CMP_BACK;
    if (phase_q == PH_APPLY) begin
      cmd.push_front = wr.push_front;
      cmd.push_back  = wr.push_back;
      cmd.pop_front  = wr.pop_front;
    end
  end

  always_comb begin
    case (phase_q)
      PH_IDLE:  phase_d = accept ? PH_MATCH : PH_IDLE;
      PH_MATCH: phase_d = PH_APPLY;
      PH_APPLY: phase_d = PH_IDLE;
      default:  phase_d = PH_IDLE;
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] prev_w;
    logic signed [VAL_W-1:0] next_w;
    if (i == 0) begin : g_first
      assign prev_w = val_q;
    end else begin : g_prev
      assign prev_w = data_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_next
      assign next_w = data_w[i+1];
    end
    deq_cell #(
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .value_i (val_q),
      .prev_i  (prev_w),
      .next_i  (next_w),
      .count_i (count_q),
      .cmd_i   (cmd),
      .data_o  (data_w[i]),
      .hit_o   (hit_w[i])
    );
  end

  deq_or_tree #(
    .N (DEPTH)
  ) u_or_tree (
    .clk_i (clk_i),
    .hit_i (hit_w),
    .any_o (any_hit)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_i;
      val_q <= value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      count_q <= '0;
      valid_o <= 1'b0;
    end else begin
      phase_q <= phase_d;
      valid_o <= phase_q == PH_APPLY;
      if (phase_q == PH_APPLY) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (phase_q == PH_APPLY) begin
      status_o   <= st_d;
      count_o    <= CNT_W'(count_d);
      is_empty_o <= count_d == '0;
    end
  end

  a_valid_after_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(phase_q) == PH_APPLY)
    else $error("result shown without an apply cycle");

  a_accept_starts_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> phase_q == PH_MATCH)
    else $error("taken item did not enter the match cycle");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_C)
    else $error("count above capacity");

  a_full_refusal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o == ST_FULL) |-> count_q == FULL_C)
    else $error("push refused while not full");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> is_empty_o == (count_q == '0))
    else $error("empty flag disagrees with count");

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top
  import deq_pkg::*;
();

  localparam int DEPTH          = 1024;
  localparam int RANDOM_ITEMS   = 1825;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_DIRECTED     = 25;
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [CNT_W-1:0] count;
    logic             is_empty;
  } deq_result_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [VAL_W-1:0] value;
    deq_result_t      res;
  } deq_row_t;

  typedef enum logic [1:0] {TR_MIXED, TR_FILL, TR_AT_FULL} traffic_e;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic        [OP_W-1:0]  op_i;
  logic signed [VAL_W-1:0] value_i;
  logic                    valid_o;
  logic        [ST_W-1:0]  status_o;
  logic        [CNT_W-1:0] count_o;
  logic                    is_empty_o;

  logic [VAL_W-1:0] deq_store [DEPTH];
  int unsigned      head_idx;
  int unsigned      tail_idx;
  int unsigned      fill_count;

  deq_result_t expected_results [$];
  int          n_mismatch;
  int          n_issued;
  int          no_gap_left;
  int          idle_count;

  deq_row_t directed_rows [N_DIRECTED] = '{
    '{OP_POP_FRONT,  32'h0000_0000, '{ST_MISS, 11'd0, 1'b1}},
    '{OP_POP_BACK,   32'h0000_0000, '{ST_MISS, 11'd0, 1'b1}},
    '{OP_CMP_FRONT,  32'h0000_0000, '{ST_MISS, 11'd0, 1'b1}},
    '{OP_CMP_BACK,   32'h0000_0000, '{ST_MISS, 11'd0, 1'b1}},
    '{OP_CLEAR,      32'h0000_0000, '{ST_OK,   11'd0, 1'b1}},
    '{OP_PUSH_BACK,  32'h7FFF_FFFF, '{ST_OK,   11'd1, 1'b0}},
    '{OP_PUSH_FRONT, 32'h8000_0000, '{ST_OK,   11'd2, 1'b0}},
    '{OP_CMP_FRONT,  32'h8000_0000, '{ST_OK,   11'd2, 1'b0}},
    '{OP_CMP_BACK,   32'h7FFF_FFFF, '{ST_OK,   11'd2, 1'b0}},
    '{OP_CMP_FRONT,  32'h7FFF_FFFF, '{ST_MISS, 11'd2, 1'b0}},
    '{OP_CMP_BACK,   32'hFFFF_FFFF, '{ST_MISS, 11'd2, 1'b0}},
    '{OP_PUSH_BACK,  32'hFFFF_FFFF, '{ST_OK,   11'd3, 1'b0}},
    '{OP_PUSH_FRONT, 32'h0000_0000, '{ST_OK,   11'd4, 1'b0}},
    '{OP_CMP_BACK,   32'hFFFF_FFFF, '{ST_OK,   11'd4, 1'b0}},
    '{OP_CMP_FRONT,  32'h0000_0000, '{ST_OK,   11'd4, 1'b0}},
    '{OP_CMP_FRONT,  32'h0000_0001, '{ST_MISS, 11'd4, 1'b0}},
    '{OP_UNUSED,     32'h1234_5678, '{ST_OK,   11'd4, 1'b0}},
    '{OP_POP_FRONT,  32'h0000_0000, '{ST_OK,   11'd3, 1'b0}},
    '{OP_CMP_FRONT,  32'h8000_0000, '{ST_OK,   11'd3, 1'b0}},
    '{OP_POP_BACK,   32'h0000_0000, '{ST_OK,   11'd2, 1'b0}},
    '{OP_CMP_BACK,   32'h7FFF_FFFF, '{ST_OK,   11'd2, 1'b0}},
    '{OP_CLEAR,      32'h0000_0000, '{ST_OK,   11'd0, 1'b1}},
    '{OP_CMP_BACK,   32'h7FFF_FFFF, '{ST_MISS, 11'd0, 1'b1}},
    '{OP_PUSH_FRONT, 32'h5555_5555, '{ST_OK,   11'd1, 1'b0}},
    '{OP_CMP_BACK,   32'h5555_5555, '{ST_OK,   11'd1, 1'b0}}
  };

  double_ended_queue #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .op_i      (op_i),
    .value_i   (value_i),
    .valid_o   (valid_o),
    .status_o  (status_o),
    .count_o   (count_o),
    .is_empty_o(is_empty_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned wrap_up(input int unsigned p);
    return (p + 1 >= DEPTH) ? 0 : p + 1;
  endfunction

  function automatic int unsigned wrap_down(input int unsigned p);
    return (p == 0) ? DEPTH - 1 : p - 1;
  endfunction

  function automatic deq_result_t deque_apply(input logic [OP_W-1:0] op,
                                              input logic [VAL_W-1:0] val);
    deq_result_t r;
    r.status = ST_OK;
    case (op)
      OP_PUSH_FRONT: begin
        if (fill_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          head_idx = wrap_down(head_idx);
          deq_store[head_idx] = val;
          fill_count++;
        end
      end
      OP_PUSH_BACK: begin
        if (fill_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          deq_store[tail_idx] = val;
          tail_idx = wrap_up(tail_idx);
          fill_count++;
        end
      end
      OP_POP_FRONT: begin
        if (fill_count == 0) begin
          r.status = ST_MISS;
        end else begin
          head_idx = wrap_up(head_idx);
          fill_count--;
        end
      end
      OP_POP_BACK: begin
        if (fill_count == 0) begin
          r.status = ST_MISS;
        end else begin
          tail_idx = wrap_down(tail_idx);
          fill_count--;
        end
      end
      OP_CMP_FRONT: begin
        if (fill_count == 0 || deq_store[head_idx] != val) r.status = ST_MISS;
      end
      OP_CMP_BACK: begin
        if (fill_count == 0 || deq_store[wrap_down(tail_idx)] != val) r.status = ST_MISS;
      end
      OP_CLEAR: begin
        head_idx   = 0;
        tail_idx   = 0;
        fill_count = 0;
      end
      default: begin
      end
    endcase
    r.count    = fill_count[CNT_W-1:0];
    r.is_empty = (fill_count == 0);
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] random_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // mostly the stored end value, sometimes one bit off, sometimes anything
  function automatic logic [VAL_W-1:0] compare_value(input logic at_front);
    logic [VAL_W-1:0] v;
    int unsigned      r;
    r = $urandom_range(0, 9);
    if (fill_count == 0 || r >= 8) return random_value();
    v = at_front ? deq_store[head_idx] : deq_store[wrap_down(tail_idx)];
    if (r >= 6) v[$urandom_range(0, VAL_W - 1)] ^= 1'b1;
    return v;
  endfunction

  function automatic logic [OP_W-1:0] pick_op(input traffic_e mode);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (mode)
      TR_FILL: begin
        if (r < 45) return OP_PUSH_FRONT;
        if (r < 90) return OP_PUSH_BACK;
        if (r < 95) return OP_CMP_FRONT;
        if (r < 98) return OP_CMP_BACK;
        if (r < 99) return OP_POP_FRONT;
        return OP_POP_BACK;
      end
      TR_AT_FULL: begin
        if (r < 30) return OP_PUSH_FRONT;
        if (r < 60) return OP_PUSH_BACK;
        if (r < 75) return OP_CMP_FRONT;
        if (r < 90) return OP_CMP_BACK;
        if (r < 95) return OP_POP_FRONT;
        return OP_POP_BACK;
      end
      default: begin
        if (r < 20) return OP_PUSH_FRONT;
        if (r < 40) return OP_PUSH_BACK;
        if (r < 54) return OP_POP_FRONT;
        if (r < 68) return OP_POP_BACK;
        if (r < 82) return OP_CMP_FRONT;
        if (r < 96) return OP_CMP_BACK;
        if (r < 99) return OP_CLEAR;
        return OP_UNUSED;
      end
    endcase
  endfunction

  function automatic int idle_cycles();
    int unsigned r;
    if (no_gap_left > 0) begin
      no_gap_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      no_gap_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic issue_item(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val,
                            input logic typed, input deq_result_t typed_res);
    int          gap;
    deq_result_t res;
    gap = idle_cycles();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start   <= 1'b1;
    op_i    <= op;
    value_i <= val;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    res = deque_apply(op, val);
    expected_results.push_back(typed ? typed_res : res);
    n_issued++;
  endtask

  task automatic issue_random(input traffic_e mode);
    logic [OP_W-1:0]  op;
    logic [VAL_W-1:0] val;
    op = pick_op(mode);
    case (op)
      OP_CMP_FRONT: val = compare_value(1'b1);
      OP_CMP_BACK:  val = compare_value(1'b0);
      default:      val = random_value();
    endcase
    issue_item(op, val, 1'b0, '0);
  endtask

  task automatic report_mismatch(input deq_result_t exp_res);
    n_mismatch++;
    if (n_mismatch <= 10) begin
      $display("mismatch at %0t: expected status %0d count %0d empty %0d, got %0d %0d %0d",
               $realtime, exp_res.status, exp_res.count, exp_res.is_empty,
               status_o, count_o, is_empty_o);
    end
  endtask

  always @(posedge clk_i) begin
    deq_result_t exp_res;
    if (rst_ni && valid_o) begin
      if (expected_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        exp_res = expected_results.pop_front();
        if (status_o !== exp_res.status || count_o !== exp_res.count ||
            is_empty_o !== exp_res.is_empty) begin
          report_mismatch(exp_res);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || valid_o) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
    end
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int n_rest;
    rst_ni      = 1'b0;
    start       = 1'b0;
    op_i        = OP_PUSH_FRONT;
    value_i     = '0;
    head_idx    = 0;
    tail_idx    = 0;
    fill_count  = 0;
    n_mismatch  = 0;
    n_issued    = 0;
    no_gap_left = 0;
    idle_count  = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIRECTED; i++) begin
      issue_item(directed_rows[i].op, directed_rows[i].value, 1'b1, directed_rows[i].res);
    end

    repeat (300) issue_random(TR_MIXED);
    // fill to capacity, then hammer the full deque
    while (fill_count < DEPTH) issue_random(TR_FILL);
    repeat (40) issue_random(TR_AT_FULL);
    issue_item(OP_CLEAR, random_value(), 1'b0, '0);
    n_rest = N_DIRECTED + RANDOM_ITEMS - n_issued;
    if (n_rest < 100) n_rest = 100;
    repeat (n_rest) issue_random(TR_MIXED);
    start <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (n_mismatch == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/deq_pkg.sv
rtl/core/deq_cell.sv
rtl/core/deq_or_tree.sv
rtl/core/double_ended_queue.sv
sim/tb_top.sv
